[rtl/line_scrollback_ring_buffer_unit_defines.svh]
// assertion macros for the line scrollback ring buffer unit
// expects i_clk and i_rst_n in the scope of every use
`ifndef LINE_SCROLLBACK_RING_BUFFER_UNIT_DEFINES_SVH
`define LINE_SCROLLBACK_RING_BUFFER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// check while out of reset
`define LSRB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// check at every edge, reset included
`define LSRB_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define LSRB_ASSERT(label, prop, msg)
`define LSRB_ASSERT_RST(label, prop, msg)
`endif
`endif

[rtl/lsrb_pkg.sv]
// shared types, codes and constants of the line scrollback ring buffer unit
// no dependencies
package lsrb_pkg;

    // default sizes
    localparam int CAPACITY_DEF  = 1024;
    localparam int MAX_LINES_DEF = 64;

    // command queue depth between front and back, a power of two
    localparam int QDEPTH = 2;

    // field widths
    localparam int MODE_W     = 2;
    localparam int LEN_W      = 11;
    localparam int CHAR_W     = 8;
    localparam int STATUS_W   = 2;
    localparam int OUT_POS_W  = 10;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 24;

    localparam logic [CHAR_W-1:0] NL_CHAR = 8'h0A;

    // item kinds
    localparam logic [MODE_W-1:0] OP_START = 2'd0;
    localparam logic [MODE_W-1:0] OP_CHAR  = 2'd1;
    localparam logic [MODE_W-1:0] OP_END   = 2'd2;
    localparam logic [MODE_W-1:0] OP_LIST  = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_TOO_LONG = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_ROOM  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_IDX_ERR  = 2'd3;

    // classified command handed from front to back
    typedef struct packed {
        logic [MODE_W-1:0] op;
        logic              too_long;
        logic [LEN_W-1:0]  len;
        logic [CHAR_W-1:0] chr;
    } t_cmd;

endpackage

[rtl/lsrb_ram.sv]
// generic single write port, single read port ram with registered read
// no dependencies
module lsrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port, read data holds without a read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/lsrb_front.sv]
// front end: accepts input words, classifies them and queues commands
// depends on lsrb_pkg
module lsrb_front #(
    parameter int CAPACITY = lsrb_pkg::CAPACITY_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [lsrb_pkg::IN_TDATA_W-1:0] i_s_tdata,  // line_length, char_byte, zero pad
    input  logic [lsrb_pkg::MODE_W-1:0]     i_s_tuser,  // mode
    output logic                            o_cmd_valid,
    output lsrb_pkg::t_cmd                  o_cmd,
    input  logic                            i_cmd_pop
);
    import lsrb_pkg::*;

    localparam int PW  = $clog2(CAPACITY);
    localparam int LW  = (PW + 1 > LEN_W) ? PW + 1 : LEN_W;
    localparam int QAW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCW = $clog2(QDEPTH + 1);

    t_cmd             r_q [QDEPTH];
    logic [QAW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [QAW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [QCW-1:0]   r_count, n_count;
    t_cmd             cmd_in;
    logic [LEN_W-1:0] len_in;
    logic             push;
    logic             pop;

    // classify the incoming word
    assign len_in          = i_s_tdata[LEN_W-1:0];
    assign cmd_in.op       = i_s_tuser;
    assign cmd_in.len      = len_in;
    assign cmd_in.chr      = i_s_tdata[LEN_W +: CHAR_W];
    assign cmd_in.too_long = LW'(len_in) > LW'(CAPACITY - 2);

    // queue handshake
    assign o_s_tready  = r_count != QCW'(QDEPTH);
    assign push        = i_s_tvalid && o_s_tready;
    assign pop         = i_cmd_pop && o_cmd_valid;
    assign o_cmd_valid = r_count != '0;
    assign o_cmd       = r_q[r_rd_ptr];

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= cmd_in;
        end
    end

endmodule

[rtl/lsrb_back.sv]
// back end: ring store, eviction and listing walks, result register
// depends on lsrb_pkg, lsrb_ram and the assertion macro header
`include "line_scrollback_ring_buffer_unit_defines.svh"
module lsrb_back #(
    parameter int CAPACITY  = lsrb_pkg::CAPACITY_DEF,
    parameter int MAX_LINES = lsrb_pkg::MAX_LINES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cmd_valid,
    input  lsrb_pkg::t_cmd                 i_cmd,
    output logic                           o_cmd_pop,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [lsrb_pkg::STATUS_W-1:0]  o_status,
    output logic [lsrb_pkg::OUT_POS_W-1:0] o_line_start,
    output logic                           o_line_valid,
    output logic [lsrb_pkg::OUT_POS_W-1:0] o_used_count,
    output logic                           o_last
);
    import lsrb_pkg::*;

    localparam int PW = $clog2(CAPACITY);
    localparam int CW = ((PW > LEN_W) ? PW : LEN_W) + 2;
    localparam int NW = $clog2(MAX_LINES + 1);
    localparam logic [PW-1:0] LAST_POS = PW'(CAPACITY - 1);
    localparam logic [PW:0]   CAP_W    = (PW + 1)'(CAPACITY);

    // sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EVAL   = 3'd1;
    localparam logic [2:0] S_EV_CHK = 3'd2;
    localparam logic [2:0] S_L_CHK  = 3'd3;
    localparam logic [2:0] S_FIN    = 3'd4;

    logic [2:0]          r_state, n_state;
    logic [PW-1:0]       r_head, n_head;
    logic [PW-1:0]       r_tail, n_tail;
    logic [LEN_W-1:0]    r_resv, n_resv;
    logic [LEN_W-1:0]    r_len, n_len;
    logic [PW-1:0]       r_cur, n_cur;
    logic [PW-1:0]       r_start, n_start;
    logic [NW-1:0]       r_nlines, n_nlines;
    logic                r_err, n_err;
    logic                r_pend_v, n_pend_v;
    logic [PW-1:0]       r_pend_start, n_pend_start;

    logic                r_out_v;
    logic [STATUS_W-1:0] r_out_status;
    logic [OUT_POS_W-1:0] r_out_start;
    logic                r_out_lvalid;
    logic [OUT_POS_W-1:0] r_out_used;
    logic                r_out_last;

    logic                out_free;
    logic                out_load;
    logic [STATUS_W-1:0] e_status;
    logic [PW-1:0]       e_start;
    logic                e_lvalid;
    logic                e_last;

    logic                ram_we;
    logic [CHAR_W-1:0]   ram_wdata;
    logic                ram_re;
    logic [PW-1:0]       ram_raddr;
    logic [CHAR_W-1:0]   ram_rdata;

    logic [PW-1:0]       used;
    logic                full;
    logic                fits;
    logic [CW-1:0]       need;
    logic [PW-1:0]       adv_head;
    logic [PW-1:0]       adv_cur;

    // next position around the ring
    function automatic logic [PW-1:0] adv(input logic [PW-1:0] p);
        return (p == LAST_POS) ? '0 : p + 1'b1;
    endfunction

    // characters between head and tail
    function automatic logic [PW-1:0] used_of(input logic [PW-1:0] h,
                                              input logic [PW-1:0] t);
        logic [PW:0] diff;
        diff = {1'b0, t} - {1'b0, h};
        if (diff[PW]) begin
            diff = diff + CAP_W;
        end
        return diff[PW-1:0];
    endfunction

    // position to the 10-bit output field
    function automatic logic [OUT_POS_W-1:0] to_out(input logic [PW-1:0] v);
        logic [PW+OUT_POS_W-1:0] t;
        t = {{OUT_POS_W{1'b0}}, v};
        return t[OUT_POS_W-1:0];
    endfunction

    assign used     = used_of(r_head, r_tail);
    assign full     = used == LAST_POS;
    assign need     = CW'(used) + CW'(r_len) + CW'(2);
    assign fits     = need <= CW'(CAPACITY);
    assign adv_head = adv(r_head);
    assign adv_cur  = adv(r_cur);
    assign out_free = !r_out_v || i_m_tready;

    lsrb_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_tail),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // command sequencer
    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_tail       = r_tail;
        n_resv       = r_resv;
        n_len        = r_len;
        n_cur        = r_cur;
        n_start      = r_start;
        n_nlines     = r_nlines;
        n_err        = r_err;
        n_pend_v     = r_pend_v;
        n_pend_start = r_pend_start;
        o_cmd_pop    = 1'b0;
        out_load     = 1'b0;
        e_status     = ST_OK;
        e_start      = '0;
        e_lvalid     = 1'b0;
        e_last       = 1'b1;
        ram_we       = 1'b0;
        ram_wdata    = i_cmd.chr;
        ram_re       = 1'b0;
        ram_raddr    = r_head;

        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    case (i_cmd.op)
                        OP_START: begin
                            if (i_cmd.too_long) begin
                                if (out_free) begin
                                    n_resv    = '0;
                                    e_status  = ST_TOO_LONG;
                                    out_load  = 1'b1;
                                    o_cmd_pop = 1'b1;
                                end
                            end else begin
                                n_len   = i_cmd.len;
                                n_state = S_EVAL;
                            end
                        end
                        OP_CHAR: begin
                            if (out_free) begin
                                if (r_resv == '0 || full) begin
                                    e_status = ST_NO_ROOM;
                                end else begin
                                    ram_we = 1'b1;
                                    n_tail = adv(r_tail);
                                    n_resv = r_resv - 1'b1;
                                end
                                out_load  = 1'b1;
                                o_cmd_pop = 1'b1;
                            end
                        end
                        OP_END: begin
                            if (out_free) begin
                                n_resv = '0;
                                if (full) begin
                                    e_status = ST_NO_ROOM;
                                end else begin
                                    ram_we    = 1'b1;
                                    ram_wdata = NL_CHAR;
                                    n_tail    = adv(r_tail);
                                end
                                out_load  = 1'b1;
                                o_cmd_pop = 1'b1;
                            end
                        end
                        OP_LIST: begin
                            n_cur    = r_head;
                            n_start  = r_head;
                            n_nlines = '0;
                            n_err    = 1'b0;
                            n_pend_v = 1'b0;
                            if (r_head == r_tail) begin
                                n_state = S_FIN;
                            end else begin
                                ram_re    = 1'b1;
                                ram_raddr = r_head;
                                n_state   = S_L_CHK;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end

            // evict more lines or grant the reservation
            S_EVAL: begin
                if (used == '0 || fits) begin
                    if (out_free) begin
                        n_resv    = r_len;
                        out_load  = 1'b1;
                        o_cmd_pop = 1'b1;
                        n_state   = S_IDLE;
                    end
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = r_head;
                    n_state   = S_EV_CHK;
                end
            end

            // head walks one character a cycle up to and past a newline, or up to the tail
            S_EV_CHK: begin
                n_head = adv_head;
                if (ram_rdata == NL_CHAR || adv_head == r_tail) begin
                    n_state = S_EVAL;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = adv_head;
                end
            end

            // listing walk, a found line start is held until the next is known
            S_L_CHK: begin
                if (ram_rdata == NL_CHAR) begin
                    if (r_nlines == NW'(MAX_LINES)) begin
                        n_err   = 1'b1;
                        n_state = S_FIN;
                    end else if (!r_pend_v || out_free) begin
                        if (r_pend_v) begin
                            e_start  = r_pend_start;
                            e_lvalid = 1'b1;
                            e_last   = 1'b0;
                            out_load = 1'b1;
                        end
                        n_pend_v     = 1'b1;
                        n_pend_start = r_start;
                        n_nlines     = r_nlines + 1'b1;
                        n_cur        = adv_cur;
                        n_start      = adv_cur;
                        if (adv_cur == r_tail) begin
                            n_state = S_FIN;
                        end else begin
                            ram_re    = 1'b1;
                            ram_raddr = adv_cur;
                        end
                    end
                end else begin
                    n_cur = adv_cur;
                    if (adv_cur == r_tail) begin
                        n_err   = 1'b1;
                        n_state = S_FIN;
                    end else begin
                        ram_re    = 1'b1;
                        ram_raddr = adv_cur;
                    end
                end
            end

            // closing result of a listing
            S_FIN: begin
                if (out_free) begin
                    e_status  = r_err ? ST_IDX_ERR : ST_OK;
                    e_start   = r_pend_v ? r_pend_start : '0;
                    e_lvalid  = r_pend_v;
                    out_load  = 1'b1;
                    o_cmd_pop = 1'b1;
                    n_state   = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= '0;
            r_tail   <= '0;
            r_resv   <= '0;
            r_nlines <= '0;
            r_err    <= 1'b0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_resv   <= n_resv;
            r_nlines <= n_nlines;
            r_err    <= n_err;
            r_pend_v <= n_pend_v;
            if (out_load) begin
                r_out_v <= 1'b1;
            end else if (i_m_tready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // walk pointers and result payload
    always_ff @(posedge i_clk) begin
        r_len        <= n_len;
        r_cur        <= n_cur;
        r_start      <= n_start;
        r_pend_start <= n_pend_start;
        if (out_load) begin
            r_out_status <= e_status;
            r_out_start  <= to_out(e_start);
            r_out_lvalid <= e_lvalid;
            r_out_used   <= to_out(used_of(n_head, n_tail));
            r_out_last   <= e_last;
        end
    end

    assign o_m_tvalid   = r_out_v;
    assign o_status     = r_out_status;
    assign o_line_start = r_out_start;
    assign o_line_valid = r_out_lvalid;
    assign o_used_count = r_out_used;
    assign o_last       = r_out_last;

    // checks
    `LSRB_ASSERT(a_pop_with_result, o_cmd_pop |-> out_load, "command retired without a result")
    `LSRB_ASSERT(a_evict_keeps_tail, (r_state == S_EV_CHK) |=> $stable(r_tail), "tail moved in eviction")
    `LSRB_ASSERT(a_list_keeps_ring, (r_state == S_L_CHK) |=> $stable(r_head) && $stable(r_tail), "ring moved in listing")
    `LSRB_ASSERT(a_no_write_in_walk, (r_state != S_IDLE) |-> !ram_we, "store written during a walk")
    `LSRB_ASSERT_RST(a_reset_clears_out, !i_rst_n |=> !r_out_v, "result valid after reset")

endmodule

[rtl/line_scrollback_ring_buffer_unit.sv]
// Character, end-line and rejected start words pass the queue register, then the result register;
// one word every cycle when they follow and each result is taken.
// Accepted start words: queue register, evaluation, eviction of whole lines character by character, result register.
// List words walk every stored character, one result per line; an empty store gives one result without a line.
// The store walk reads one character a cycle from the single ram read port, but a listing waits while a result is held.
// Reset clears head, tail, reservation, queue pointers and result valid flag; the store keeps its data.
module line_scrollback_ring_buffer_unit #(
    parameter int CAPACITY  = lsrb_pkg::CAPACITY_DEF,
    parameter int MAX_LINES = lsrb_pkg::MAX_LINES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [lsrb_pkg::IN_TDATA_W-1:0]  i_s_tdata,  // line_length, char_byte, zero pad
    input  logic [lsrb_pkg::MODE_W-1:0]      i_s_tuser,  // mode
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [lsrb_pkg::OUT_TDATA_W-1:0] o_m_tdata,  // status, line_start, used_count, zero pad
    output logic                             o_m_tuser,  // line_valid
    output logic                             o_m_tlast
);
    import lsrb_pkg::*;

    t_cmd                 cmd;
    logic                 cmd_valid;
    logic                 cmd_pop;
    logic [STATUS_W-1:0]  status;
    logic [OUT_POS_W-1:0] line_start;
    logic [OUT_POS_W-1:0] used_count;

    lsrb_front #(
        .CAPACITY (CAPACITY)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    lsrb_back #(
        .CAPACITY  (CAPACITY),
        .MAX_LINES (MAX_LINES)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (cmd_valid),
        .i_cmd        (cmd),
        .o_cmd_pop    (cmd_pop),
        .o_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .o_status     (status),
        .o_line_start (line_start),
        .o_line_valid (o_m_tuser),
        .o_used_count (used_count),
        .o_last       (o_m_tlast)
    );

    // pack the result word
    assign o_m_tdata = {{(OUT_TDATA_W - STATUS_W - 2 * OUT_POS_W){1'b0}},
                        used_count, line_start, status};

endmodule
